@@ sv/crdt_pkg.sv @@
// Shared constants of the circle revisit dwell tracker.
// Holds the register-port sizes, register indexes and the dwell width.
// No dependencies.
`default_nettype none

package crdt_pkg;

    // register port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // register indexes (byte address / 8)
    localparam logic [1:0] REG_CENTER_X  = 2'd0;
    localparam logic [1:0] REG_CENTER_Y  = 2'd1;
    localparam logic [1:0] REG_RADIUS    = 2'd2;
    localparam logic [1:0] REG_MERGE_GAP = 2'd3;

    // dwell accumulator width
    localparam int DWELL_WIDTH = 48;

endpackage

`default_nettype wire

@@ sv/circle_revisit_dwell_tracker.sv @@
// Circle revisit dwell tracker: counts visits of a track to one circle and their
// total residence time, interpolating crossing times along each segment and
// merging short excursions. A point that stays on one side of the boundary
// needs three squarings on the shared multiplier; a point whose segment
// crosses the boundary adds a 16-step bisection for the crossing fraction,
// each step four products. Every product runs on the iterative byte-wide
// multiplier. The result of a final point waits in an output register while
// the next request is taken.
// Uses crdt_pkg, crdt_regs and crdt_mul.
`default_nettype none

module circle_revisit_dwell_tracker #(
    parameter int COORD_WIDTH   = 32,
    parameter int TIME_WIDTH    = 40,
    parameter int COUNT_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: pos_x, pos_y, stamp (from bit 0 up), zero padded to bytes
    input  wire logic [((2*COORD_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser: track_start, final_point (from bit 0 up)
    input  wire logic [1:0]                      s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: visit_count, dwell_total (from bit 0 up), zero padded to bytes
    output logic [((COUNT_WIDTH+crdt_pkg::DWELL_WIDTH+7)/8)*8-1:0] m_tdata,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [crdt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [crdt_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [crdt_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int C   = COORD_WIDTH;
    localparam int T   = TIME_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int DWL = crdt_pkg::DWELL_WIDTH;
    localparam int DW  = C + 1;
    localparam int TW  = C + F + 2;
    localparam int MW  = (TW > T) ? TW : T;
    localparam int PW  = 2 * MW;
    localparam int CW  = PW + 2 * F + 1;
    localparam int MDW = ((COUNT_WIDTH + DWL + 7) / 8) * 8;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQDX   = 4'd1;
    localparam logic [3:0] ST_SQDY   = 4'd2;
    localparam logic [3:0] ST_SQR    = 4'd3;
    localparam logic [3:0] ST_DECIDE = 4'd4;
    localparam logic [3:0] ST_SETUP  = 4'd5;
    localparam logic [3:0] ST_KX     = 4'd6;
    localparam logic [3:0] ST_SQX    = 4'd7;
    localparam logic [3:0] ST_KY     = 4'd8;
    localparam logic [3:0] ST_SQY    = 4'd9;
    localparam logic [3:0] ST_SCALE  = 4'd10;
    localparam logic [3:0] ST_POST   = 4'd11;

    // sign and magnitude of a - b
    function automatic logic [DW:0] absdiff(input logic signed [C-1:0] a,
                                            input logic signed [C-1:0] b);
        logic signed [DW-1:0] d;
        d = {a[C-1], a} - {b[C-1], b};
        return {d[DW-1], (d[DW-1] ? DW'(-d) : DW'(d))};
    endfunction

    function automatic logic [T-1:0] tdiff(input logic [T-1:0] a, input logic [T-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [DWL-1:0] dwell_add(input logic [DWL-1:0] d,
                                                 input logic [T-1:0] v);
        logic [DWL:0] s;
        s = {1'b0, d} + (DWL+1)'(v);
        return s[DWL] ? '1 : s[DWL-1:0];
    endfunction

    // one axis term: k*dm combined with em scaled by 2^F
    function automatic logic [TW-1:0] combine(input logic [TW-1:0] x,
                                              input logic [DW-1:0] em,
                                              input logic same);
        logic [TW-1:0] y;
        y = TW'(em) << F;
        if (same)
            return x + y;
        return (x >= y) ? x - y : y - x;
    endfunction

    // configuration
    logic signed [C-1:0] center_x, center_y;
    logic [C-2:0]        radius;
    logic [T-1:0]        merge_gap;

    crdt_regs #(
        .COORD_WIDTH (C),
        .TIME_WIDTH  (T)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .merge_gap (merge_gap)
    );

    // sequencer and tracking state
    logic [3:0]          state_reg, state_next;
    logic                issued_reg, issued_next;
    logic signed [C-1:0] x_reg, x_next, y_reg, y_next;
    logic [T-1:0]        t_reg, t_next;
    logic                start_reg, start_next, fin_reg, fin_next;
    logic                now_reg, now_next;
    logic [PW:0]         sum_reg, sum_next;
    logic [PW-1:0]       rr_reg, rr_next;
    logic                dir_exit_reg, dir_exit_next;
    logic [DW-1:0]       dmx_reg, dmx_next, dmy_reg, dmy_next;
    logic [DW-1:0]       emx_reg, emx_next, emy_reg, emy_next;
    logic                samex_reg, samex_next, samey_reg, samey_next;
    logic [F-1:0]        lo_reg, lo_next;
    logic [F:0]          hi_reg, hi_next;
    logic [TW-1:0]       u_reg, u_next;
    logic [T-1:0]        dt_reg, dt_next;

    logic                inside_reg, inside_next;
    logic                merging_reg, merging_next;
    logic                exit_seen_reg, exit_seen_next;
    logic [T-1:0]        entry_reg, entry_next, exit_reg, exit_next;
    logic signed [C-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [T-1:0]        prev_t_reg, prev_t_next;
    logic [COUNT_WIDTH-1:0] visits_reg, visits_next;
    logic [DWL-1:0]      dwell_reg, dwell_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [MDW-1:0]      m_tdata_reg, m_tdata_next;

    // shared multiplier
    logic            mul_start, mul_done;
    logic [MW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   mul_prod;

    crdt_mul #(
        .MW (MW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    logic [DW:0]     adx, ady;
    logic [F:0]      mid_w;
    logic [F-1:0]    mid;
    logic            op_state;
    logic [T-1:0]    ev_at, off, ex_t, en_t, gap;
    logic [DWL-1:0]  ev_dwell;
    logic [COUNT_WIDTH-1:0] ev_visits;
    logic [CW-1:0]   dist_sum, rad_lim;
    logic            frac_in;
    logic [F-1:0]    new_lo;
    logic [F:0]      new_hi;

    assign adx   = absdiff(x_reg, center_x);
    assign ady   = absdiff(y_reg, center_y);
    assign mid_w = (F+1)'(lo_reg) + ((hi_reg - (F+1)'(lo_reg)) >> 1);
    assign mid   = mid_w[F-1:0];

    assign op_state = (state_reg == ST_SQDX) || (state_reg == ST_SQDY) ||
                      (state_reg == ST_SQR) || (state_reg == ST_KX) ||
                      (state_reg == ST_SQX) || (state_reg == ST_KY) ||
                      (state_reg == ST_SQY) || (state_reg == ST_SCALE);
    assign mul_start = op_state && !issued_reg;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQDX:  begin mul_a = MW'(adx[DW-1:0]); mul_b = MW'(adx[DW-1:0]); end
            ST_SQDY:  begin mul_a = MW'(ady[DW-1:0]); mul_b = MW'(ady[DW-1:0]); end
            ST_SQR:   begin mul_a = MW'(radius);      mul_b = MW'(radius);      end
            ST_KX:    begin mul_a = MW'(dmx_reg);     mul_b = MW'(mid);         end
            ST_KY:    begin mul_a = MW'(dmy_reg);     mul_b = MW'(mid);         end
            ST_SQX,
            ST_SQY:   begin mul_a = MW'(u_reg);       mul_b = MW'(u_reg);       end
            ST_SCALE: begin mul_a = MW'(dt_reg);      mul_b = MW'(lo_reg);      end
            default: ;
        endcase
    end

    // interpolated stamps and bisection step
    assign off      = mul_prod[F+T-1:F];
    assign ex_t     = prev_t_reg + off;
    assign en_t     = t_reg - off;
    assign gap      = tdiff(en_t, exit_reg);
    assign dist_sum = CW'(sum_reg) + CW'(mul_prod);
    assign rad_lim  = CW'(rr_reg) << (2 * F);
    assign frac_in  = dist_sum <= rad_lim;
    assign new_lo   = frac_in ? mid : lo_reg;
    assign new_hi   = frac_in ? hi_reg : (F+1)'(mid);

    // closing a visit
    always_comb begin
        case (state_reg)
            ST_DECIDE: ev_at = prev_t_reg;
            ST_SCALE:  ev_at = ex_t;
            default:   ev_at = t_reg;
        endcase
        ev_dwell  = dwell_add(dwell_reg, tdiff(ev_at, entry_reg));
        ev_visits = (!merging_reg && visits_reg != '1) ? visits_reg + 1'b1 : visits_reg;
    end

    // sequencer
    always_comb begin
        logic [DW:0] a_dx, a_dy, a_ex, a_ey;
        logic signed [C-1:0] ax, ay, bx, by;

        state_next     = state_reg;
        issued_next    = issued_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        t_next         = t_reg;
        start_next     = start_reg;
        fin_next       = fin_reg;
        now_next       = now_reg;
        sum_next       = sum_reg;
        rr_next        = rr_reg;
        dir_exit_next  = dir_exit_reg;
        dmx_next       = dmx_reg;
        dmy_next       = dmy_reg;
        emx_next       = emx_reg;
        emy_next       = emy_reg;
        samex_next     = samex_reg;
        samey_next     = samey_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        u_next         = u_reg;
        dt_next        = dt_reg;
        inside_next    = inside_reg;
        merging_next   = merging_reg;
        exit_seen_next = exit_seen_reg;
        entry_next     = entry_reg;
        exit_next      = exit_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_t_next    = prev_t_reg;
        visits_next    = visits_reg;
        dwell_next     = dwell_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        ax   = dir_exit_reg ? prev_x_reg : x_reg;
        ay   = dir_exit_reg ? prev_y_reg : y_reg;
        bx   = dir_exit_reg ? x_reg : prev_x_reg;
        by   = dir_exit_reg ? y_reg : prev_y_reg;
        a_dx = absdiff(bx, ax);
        a_dy = absdiff(by, ay);
        a_ex = absdiff(ax, center_x);
        a_ey = absdiff(ay, center_y);

        if (mul_start)
            issued_next = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata[C-1:0];
                    y_next     = s_tdata[2*C-1:C];
                    t_next     = s_tdata[2*C+T-1:2*C];
                    start_next = s_tuser[0];
                    fin_next   = s_tuser[1];
                    state_next = ST_SQDX;
                end
            end
            ST_SQDX: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    sum_next    = (PW+1)'(mul_prod);
                    state_next  = ST_SQDY;
                end
            end
            ST_SQDY: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    sum_next    = sum_reg + (PW+1)'(mul_prod);
                    state_next  = ST_SQR;
                end
            end
            ST_SQR: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    now_next    = sum_reg <= (PW+1)'(mul_prod);
                    rr_next     = mul_prod;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (start_reg) begin
                    if (inside_reg) begin
                        dwell_next  = ev_dwell;
                        visits_next = ev_visits;
                    end
                    inside_next    = now_reg;
                    merging_next   = 1'b0;
                    exit_seen_next = 1'b0;
                    entry_next     = now_reg ? t_reg : '0;
                    exit_next      = '0;
                    state_next     = ST_POST;
                end else if (!now_reg && inside_reg) begin
                    dir_exit_next = 1'b1;
                    state_next    = ST_SETUP;
                end else if (now_reg && !inside_reg) begin
                    dir_exit_next = 1'b0;
                    state_next    = ST_SETUP;
                end else begin
                    state_next = ST_POST;
                end
            end
            ST_SETUP: begin
                dmx_next   = a_dx[DW-1:0];
                dmy_next   = a_dy[DW-1:0];
                emx_next   = a_ex[DW-1:0];
                emy_next   = a_ey[DW-1:0];
                samex_next = a_dx[DW] == a_ex[DW];
                samey_next = a_dy[DW] == a_ey[DW];
                lo_next    = '0;
                hi_next    = (F+1)'(1) << F;
                dt_next    = tdiff(t_reg, prev_t_reg);
                state_next = ST_KX;
            end
            ST_KX: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    u_next      = combine(mul_prod[TW-1:0], emx_reg, samex_reg);
                    state_next  = ST_SQX;
                end
            end
            ST_SQX: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    sum_next    = (PW+1)'(mul_prod);
                    state_next  = ST_KY;
                end
            end
            ST_KY: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    u_next      = combine(mul_prod[TW-1:0], emy_reg, samey_reg);
                    state_next  = ST_SQY;
                end
            end
            ST_SQY: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    lo_next     = new_lo;
                    hi_next     = new_hi;
                    if ((new_hi - (F+1)'(new_lo)) > (F+1)'(1))
                        state_next = ST_KX;
                    else
                        state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (issued_reg && mul_done) begin
                    issued_next = 1'b0;
                    if (dir_exit_reg) begin
                        dwell_next     = ev_dwell;
                        visits_next    = ev_visits;
                        inside_next    = 1'b0;
                        exit_next      = ex_t;
                        exit_seen_next = 1'b1;
                    end else begin
                        inside_next  = 1'b1;
                        entry_next   = en_t;
                        merging_next = 1'b0;
                        if (exit_seen_reg && gap < merge_gap) begin
                            merging_next = 1'b1;
                            dwell_next   = dwell_add(dwell_reg, gap);
                        end
                    end
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                prev_x_next = x_reg;
                prev_y_next = y_reg;
                prev_t_next = t_reg;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_tvalid_reg || m_tready) begin
                    // report, then back to the reset state
                    if (inside_reg)
                        m_tdata_next = MDW'({ev_dwell, ev_visits});
                    else
                        m_tdata_next = MDW'({dwell_reg, visits_reg});
                    m_tvalid_next  = 1'b1;
                    inside_next    = 1'b0;
                    merging_next   = 1'b0;
                    exit_seen_next = 1'b0;
                    entry_next     = '0;
                    exit_next      = '0;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    prev_t_next    = '0;
                    visits_next    = '0;
                    dwell_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            inside_reg    <= 1'b0;
            merging_reg   <= 1'b0;
            exit_seen_reg <= 1'b0;
            entry_reg     <= '0;
            exit_reg      <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_t_reg    <= '0;
            visits_reg    <= '0;
            dwell_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            inside_reg    <= inside_next;
            merging_reg   <= merging_next;
            exit_seen_reg <= exit_seen_next;
            entry_reg     <= entry_next;
            exit_reg      <= exit_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_t_reg    <= prev_t_next;
            visits_reg    <= visits_next;
            dwell_reg     <= dwell_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        t_reg        <= t_next;
        start_reg    <= start_next;
        fin_reg      <= fin_next;
        now_reg      <= now_next;
        sum_reg      <= sum_next;
        rr_reg       <= rr_next;
        dir_exit_reg <= dir_exit_next;
        dmx_reg      <= dmx_next;
        dmy_reg      <= dmy_next;
        emx_reg      <= emx_next;
        emy_reg      <= emy_next;
        samex_reg    <= samex_next;
        samey_reg    <= samey_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        u_reg        <= u_next;
        dt_reg       <= dt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a product only arrives for a request in flight
    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> issued_reg)
        else $error("multiplier result without a pending request");

    // bisection bracket stays ordered
    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KX || state_reg == ST_SQX || state_reg == ST_KY ||
         state_reg == ST_SQY) |-> ((F+1)'(lo_reg) < hi_reg))
        else $error("crossing bracket collapsed");

    // a result appears only from the reporting step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == ST_POST))
        else $error("result raised outside the reporting step");

endmodule

`default_nettype wire

@@ sv/crdt_mul.sv @@
// Iterative unsigned multiplier shared by every product of the tracker.
// Takes eight multiplier bits a cycle and stops once the rest are zero.
// Depends on nothing.
`default_nettype none

module crdt_mul #(
    parameter int MW = 50
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [MW-1:0]     op_a,
    input  wire logic [MW-1:0]     op_b,
    output logic                   done,
    output logic [2*MW-1:0]        prod
);

    localparam int PW = 2 * MW;

    logic [PW-1:0] a_sh_reg, a_sh_next;
    logic [MW-1:0] b_sh_reg, b_sh_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] part;

    // partial product of one multiplier byte
    assign part = a_sh_reg * {{(PW-8){1'b0}}, b_sh_reg[7:0]};

    always_comb begin
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_sh_next = PW'(op_a);
            b_sh_next = op_b;
            acc_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next  = acc_reg + part;
            a_sh_next = a_sh_reg << 8;
            b_sh_next = b_sh_reg >> 8;
            if ((b_sh_reg >> 8) == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_sh_reg <= '0;
            b_sh_reg <= '0;
            acc_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            a_sh_reg <= a_sh_next;
            b_sh_reg <= b_sh_next;
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

@@ sv/crdt_regs.sv @@
// Configuration registers of the tracker behind an APB-style port.
// Uses crdt_pkg for port sizes and register indexes.
`default_nettype none

module crdt_regs #(
    parameter int COORD_WIDTH = 32,
    parameter int TIME_WIDTH  = 40
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [crdt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [crdt_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [crdt_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic signed [COORD_WIDTH-1:0]        center_x,
    output logic signed [COORD_WIDTH-1:0]        center_y,
    output logic      [COORD_WIDTH-2:0]          radius,
    output logic      [TIME_WIDTH-1:0]           merge_gap
);

    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic [COORD_WIDTH-2:0]        rad_reg;
    logic [TIME_WIDTH-1:0]         gap_reg;
    logic                          wr;
    logic [1:0]                    idx;

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[4:3];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            rad_reg <= '0;
            gap_reg <= '0;
        end else if (wr) begin
            unique case (idx)
                crdt_pkg::REG_CENTER_X:  cx_reg  <= pwdata[COORD_WIDTH-1:0];
                crdt_pkg::REG_CENTER_Y:  cy_reg  <= pwdata[COORD_WIDTH-1:0];
                crdt_pkg::REG_RADIUS:    rad_reg <= pwdata[COORD_WIDTH-2:0];
                crdt_pkg::REG_MERGE_GAP: gap_reg <= pwdata[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        unique case (idx)
            crdt_pkg::REG_CENTER_X:  prdata = crdt_pkg::APB_DATA_W'(unsigned'(cx_reg));
            crdt_pkg::REG_CENTER_Y:  prdata = crdt_pkg::APB_DATA_W'(unsigned'(cy_reg));
            crdt_pkg::REG_RADIUS:    prdata = crdt_pkg::APB_DATA_W'(rad_reg);
            crdt_pkg::REG_MERGE_GAP: prdata = crdt_pkg::APB_DATA_W'(gap_reg);
            default:                 prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign center_x  = cx_reg;
    assign center_y  = cy_reg;
    assign radius    = rad_reg;
    assign merge_gap = gap_reg;

endmodule

`default_nettype wire
